### design/mde_pkg.sv
// Shared opcodes, function codes, ALU operations and decode control types.
`timescale 1ns / 1ps

package mde_pkg;

    localparam int XLEN = 32;
    localparam int REG_BITS = 5;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [REG_BITS-1:0] LINK_REG = 5'd31;
    localparam logic [XLEN-1:0] TOP_MASK = 32'hF000_0000;

    typedef enum logic [3:0] {
        ALU_ZERO,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_PASS_PC
    } alu_op_t;

    typedef struct packed {
        alu_op_t             alu_op;
        logic                use_imm;
        logic                reg_write;
        logic [REG_BITS-1:0] write_reg;
        logic                mem_read;
        logic                mem_write;
        logic                branch_eq;
        logic                branch_ne;
        logic                jump;
        logic                jump_reg;
        logic                link;
        logic                illegal;
    } ctrl_t;

endpackage

### design/mips_decode_execute.sv
// Top level of the decode and execute stage: input register, decode, ALU, result register.
`timescale 1ns / 1ps
// done marks a result once its transfer has passed the input and the result register.
// Throughput: one instruction per cycle; busy is never raised, since the input
// register, the decoder plus ALU, and the result register form a plain two-stage pipe.
// Reset: rst_n clears only the stage valid flags; payload registers keep no reset value.
// The receiver cannot stall, so each result is shown for exactly one cycle.

module mips_decode_execute
    import mde_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [XLEN-1:0]     instr,
    input  logic [XLEN-1:0]     rs_value,
    input  logic [XLEN-1:0]     rt_value,
    input  logic [XLEN-1:0]     next_pc,
    output logic                done,
    output logic [XLEN-1:0]     alu_result,
    output logic [REG_BITS-1:0] write_reg,
    output logic                reg_write,
    output logic                mem_read,
    output logic                mem_write,
    output logic [XLEN-1:0]     store_data,
    output logic                branch_taken,
    output logic                jump,
    output logic [XLEN-1:0]     jump_target,
    output logic                link,
    output logic                illegal
);

    // The pipe never backs up, so a new instruction is taken every cycle.
    assign busy = 1'b0;

    // Input stage registers.
    logic            in_valid_reg;
    logic [XLEN-1:0] instr_reg;
    logic [XLEN-1:0] rs_reg;
    logic [XLEN-1:0] rt_reg;
    logic [XLEN-1:0] npc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            instr_reg <= instr;
            rs_reg    <= rs_value;
            rt_reg    <= rt_value;
            npc_reg   <= next_pc;
        end
    end

    // Decode the registered instruction into a control bundle.
    ctrl_t ctrl;

    mde_decoder u_decoder (
        .instr (instr_reg),
        .ctrl  (ctrl)
    );

    // The second operand is either rt or the sign-extended immediate.
    logic [XLEN-1:0] imm_sext;
    logic [XLEN-1:0] operand_b;
    logic [XLEN-1:0] alu_out;

    assign imm_sext  = {{(XLEN-16){instr_reg[15]}}, instr_reg[15:0]};
    assign operand_b = ctrl.use_imm ? imm_sext : rt_reg;

    mde_alu u_alu (
        .alu_op   (ctrl.alu_op),
        .a        (rs_reg),
        .b        (operand_b),
        .shamt    (instr_reg[10:6]),
        .pc_value (npc_reg),
        .result   (alu_out)
    );

    // Branch decision compares rs and rt directly; the target adder lives elsewhere.
    logic            operands_equal;
    logic            taken_next;
    logic [XLEN-1:0] target_next;
    logic [XLEN-1:0] pseudo_target;

    assign operands_equal = (rs_reg == rt_reg);
    assign taken_next     = (ctrl.branch_eq && operands_equal) ||
                            (ctrl.branch_ne && !operands_equal);
    assign pseudo_target  = {4'b0000, instr_reg[25:0], 2'b00} | (npc_reg & TOP_MASK);

    // Register jumps take rs; absolute jumps splice the address field under the
    // top four bits of the sequential PC; everything else shows zero.
    always_comb
    begin
        if (ctrl.jump_reg)
        begin
            target_next = rs_reg;
        end
        else if (ctrl.jump)
        begin
            target_next = pseudo_target;
        end
        else
        begin
            target_next = '0;
        end
    end

    // Result stage registers.
    logic                done_reg;
    logic [XLEN-1:0]     alu_result_reg;
    logic [REG_BITS-1:0] write_reg_reg;
    logic                reg_write_reg;
    logic                mem_read_reg;
    logic                mem_write_reg;
    logic [XLEN-1:0]     store_data_reg;
    logic                branch_taken_reg;
    logic                jump_reg;
    logic [XLEN-1:0]     jump_target_reg;
    logic                link_reg;
    logic                illegal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            alu_result_reg   <= alu_out;
            write_reg_reg    <= ctrl.write_reg;
            reg_write_reg    <= ctrl.reg_write;
            mem_read_reg     <= ctrl.mem_read;
            mem_write_reg    <= ctrl.mem_write;
            store_data_reg   <= rt_reg;
            branch_taken_reg <= taken_next;
            jump_reg         <= ctrl.jump;
            jump_target_reg  <= target_next;
            link_reg         <= ctrl.link;
            illegal_reg      <= ctrl.illegal;
        end
    end

    assign done         = done_reg;
    assign alu_result   = alu_result_reg;
    assign write_reg    = write_reg_reg;
    assign reg_write    = reg_write_reg;
    assign mem_read     = mem_read_reg;
    assign mem_write    = mem_write_reg;
    assign store_data   = store_data_reg;
    assign branch_taken = branch_taken_reg;
    assign jump         = jump_reg;
    assign jump_target  = jump_target_reg;
    assign link         = link_reg;
    assign illegal      = illegal_reg;

    // Every accepted transfer produces exactly one result via the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted instruction produced no result");

    // No result strobe appears without an accepted instruction in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid_reg))
        else $error("result strobe without a preceding instruction");

    // An illegal instruction must not have any architectural side effect.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && illegal) |-> (!reg_write && !mem_read && !mem_write && !jump &&
                               !branch_taken && !link))
        else $error("illegal instruction raised a side effect");

    // Link always writes register 31 and jumps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && link) |-> (jump && reg_write && (write_reg == LINK_REG)))
        else $error("link without jump to register 31");

endmodule

### design/mde_decoder.sv
// Instruction decoder producing the control bundle for one instruction.
`timescale 1ns / 1ps

module mde_decoder
    import mde_pkg::*;
(
    input  logic [31:0] instr,
    output ctrl_t       ctrl
);

    logic [5:0] opcode;
    logic [5:0] funct;
    logic [4:0] rt;
    logic [4:0] rd;

    assign opcode = instr[31:26];
    assign funct  = instr[5:0];
    assign rt     = instr[20:16];
    assign rd     = instr[15:11];

    always_comb
    begin
        ctrl = '0;
        ctrl.alu_op = ALU_ZERO;
        unique case (opcode)
            OP_RTYPE:
            begin
                ctrl.reg_write = 1'b1;
                ctrl.write_reg = rd;
                unique case (funct) inside
                    FN_SLL:           ctrl.alu_op = ALU_SLL;
                    FN_SRL:           ctrl.alu_op = ALU_SRL;
                    FN_ADD, FN_ADDU:  ctrl.alu_op = ALU_ADD;
                    FN_SUB, FN_SUBU:  ctrl.alu_op = ALU_SUB;
                    FN_AND:           ctrl.alu_op = ALU_AND;
                    FN_OR:            ctrl.alu_op = ALU_OR;
                    FN_NOR:           ctrl.alu_op = ALU_NOR;
                    FN_SLT:           ctrl.alu_op = ALU_SLT;
                    FN_SLTU:          ctrl.alu_op = ALU_SLTU;
                    FN_JR:
                    begin
                        ctrl.reg_write = 1'b0;
                        ctrl.write_reg = '0;
                        ctrl.jump      = 1'b1;
                        ctrl.jump_reg  = 1'b1;
                    end
                    default:
                    begin
                        ctrl.reg_write = 1'b0;
                        ctrl.write_reg = '0;
                        ctrl.illegal   = 1'b1;
                    end
                endcase
            end
            OP_J:
            begin
                ctrl.jump = 1'b1;
            end
            OP_JAL:
            begin
                ctrl.jump      = 1'b1;
                ctrl.link      = 1'b1;
                ctrl.reg_write = 1'b1;
                ctrl.write_reg = LINK_REG;
                ctrl.alu_op    = ALU_PASS_PC;
            end
            OP_BEQ:
            begin
                ctrl.alu_op    = ALU_SUB;
                ctrl.branch_eq = 1'b1;
            end
            OP_BNE:
            begin
                ctrl.alu_op    = ALU_SUB;
                ctrl.branch_ne = 1'b1;
            end
            OP_ADDIU:
            begin
                ctrl.alu_op    = ALU_ADD;
                ctrl.use_imm   = 1'b1;
                ctrl.reg_write = 1'b1;
                ctrl.write_reg = rt;
            end
            OP_SLTI:
            begin
                ctrl.alu_op    = ALU_SLT;
                ctrl.use_imm   = 1'b1;
                ctrl.reg_write = 1'b1;
                ctrl.write_reg = rt;
            end
            OP_LW:
            begin
                ctrl.alu_op    = ALU_ADD;
                ctrl.use_imm   = 1'b1;
                ctrl.reg_write = 1'b1;
                ctrl.write_reg = rt;
                ctrl.mem_read  = 1'b1;
            end
            OP_SW:
            begin
                ctrl.alu_op    = ALU_ADD;
                ctrl.use_imm   = 1'b1;
                ctrl.mem_write = 1'b1;
            end
            default:
            begin
                ctrl.illegal = 1'b1;
            end
        endcase
    end

endmodule

### design/mde_alu.sv
// Arithmetic, logic, compare and shift unit.
`timescale 1ns / 1ps

module mde_alu
    import mde_pkg::*;
(
    input  alu_op_t         alu_op,
    input  logic [XLEN-1:0] a,
    input  logic [XLEN-1:0] b,
    input  logic [4:0]      shamt,
    input  logic [XLEN-1:0] pc_value,
    output logic [XLEN-1:0] result
);

    logic [XLEN-1:0] diff;
    logic            lt_signed;
    logic            lt_unsigned;

    assign diff        = a - b;
    assign lt_unsigned = (a < b);
    // Flipping the sign bits lets an unsigned compare give the signed result.
    assign lt_signed   = ({~a[XLEN-1], a[XLEN-2:0]} < {~b[XLEN-1], b[XLEN-2:0]});

    always_comb
    begin
        case (alu_op)
            ALU_ADD:     result = a + b;
            ALU_SUB:     result = diff;
            ALU_AND:     result = a & b;
            ALU_OR:      result = a | b;
            ALU_NOR:     result = ~(a | b);
            ALU_SLT:     result = {{(XLEN-1){1'b0}}, lt_signed};
            ALU_SLTU:    result = {{(XLEN-1){1'b0}}, lt_unsigned};
            ALU_SLL:     result = b << shamt;
            ALU_SRL:     result = b >> shamt;
            ALU_PASS_PC: result = pc_value;
            default:     result = '0;
        endcase
    end

endmodule

### tb/sv/tb_mips_decode_execute.sv
// Self-checking testbench for the MIPS subset decode and execute stage.
`timescale 1ns / 1ps

module tb_mips_decode_execute;
    import mde_pkg::*;

    // One result transfer, in port order: alu_result, write_reg, reg_write, mem_read,
    // mem_write, store_data, branch_taken, jump, jump_target, link, illegal.
    typedef struct packed {
        logic [XLEN-1:0]     alu_result;
        logic [REG_BITS-1:0] write_reg;
        logic                reg_write;
        logic                mem_read;
        logic                mem_write;
        logic [XLEN-1:0]     store_data;
        logic                branch_taken;
        logic                jump;
        logic [XLEN-1:0]     jump_target;
        logic                link;
        logic                illegal;
    } exec_result_t;

    // A directed stimulus row. When known is set, the result is typed into the row
    // and is checked as written instead of being worked out by the predictor.
    typedef struct {
        logic [XLEN-1:0] instr;
        logic [XLEN-1:0] rs_value;
        logic [XLEN-1:0] rt_value;
        logic [XLEN-1:0] next_pc;
        bit              known;
        exec_result_t    want;
    } stim_row_t;

    localparam int RANDOM_ITEMS = 850;
    // The last stretch of random items runs back to back, with no idle cycles.
    localparam int CALM_TAIL = 100;
    // Margin waited at the end for any late result strobe.
    localparam int SETTLE_CYCLES = 4;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic [XLEN-1:0] instr = '0;
    logic [XLEN-1:0] rs_value = '0;
    logic [XLEN-1:0] rt_value = '0;
    logic [XLEN-1:0] next_pc = '0;

    logic                busy;
    logic                done;
    logic [XLEN-1:0]     alu_result;
    logic [REG_BITS-1:0] write_reg;
    logic                reg_write;
    logic                mem_read;
    logic                mem_write;
    logic [XLEN-1:0]     store_data;
    logic                branch_taken;
    logic                jump;
    logic [XLEN-1:0]     jump_target;
    logic                link;
    logic                illegal;

    // Sideband that travels with each item, so that a typed result is picked up at
    // the same clock edge as the transfer that it belongs to.
    bit           row_known = 1'b0;
    exec_result_t row_want = '0;

    exec_result_t expected_exec[$];
    int           mismatch_count = 0;

    mips_decode_execute i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .instr        (instr),
        .rs_value     (rs_value),
        .rt_value     (rt_value),
        .next_pc      (next_pc),
        .done         (done),
        .alu_result   (alu_result),
        .write_reg    (write_reg),
        .reg_write    (reg_write),
        .mem_read     (mem_read),
        .mem_write    (mem_write),
        .store_data   (store_data),
        .branch_taken (branch_taken),
        .jump         (jump),
        .jump_target  (jump_target),
        .link         (link),
        .illegal      (illegal)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Instruction encoders for the directed table.
    function automatic logic [XLEN-1:0] enc_r(input logic [5:0] funct, input logic [4:0] rs,
                                              input logic [4:0] rt, input logic [4:0] rd,
                                              input logic [4:0] shamt);
        return {OP_RTYPE, rs, rt, rd, shamt, funct};
    endfunction

    function automatic logic [XLEN-1:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                              input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [XLEN-1:0] enc_j(input logic [5:0] op, input logic [25:0] addr);
        return {op, addr};
    endfunction

    // Works out the decode and ALU outcome of one instruction. The decode picks an
    // ALU operation and its second operand; the ALU step then forms the value.
    function automatic exec_result_t execute_instr(input logic [XLEN-1:0] w,
                                                   input logic [XLEN-1:0] a,
                                                   input logic [XLEN-1:0] b,
                                                   input logic [XLEN-1:0] pc);
        exec_result_t    r;
        alu_op_t         op_sel;
        logic [XLEN-1:0] imm_ext;
        logic [XLEN-1:0] operand_b;
        logic [XLEN-1:0] far_target;
        r = '0;
        r.store_data = b;
        op_sel = ALU_ZERO;
        operand_b = b;
        imm_ext = {{16{w[15]}}, w[15:0]};
        far_target = (pc & TOP_MASK) | {4'b0000, w[25:0], 2'b00};
        case (w[31:26])
            OP_RTYPE:
            begin
                r.reg_write = 1'b1;
                r.write_reg = w[15:11];
                case (w[5:0])
                    FN_SLL:           op_sel = ALU_SLL;
                    FN_SRL:           op_sel = ALU_SRL;
                    FN_ADD, FN_ADDU:  op_sel = ALU_ADD;
                    FN_SUB, FN_SUBU:  op_sel = ALU_SUB;
                    FN_AND:           op_sel = ALU_AND;
                    FN_OR:            op_sel = ALU_OR;
                    FN_NOR:           op_sel = ALU_NOR;
                    FN_SLT:           op_sel = ALU_SLT;
                    FN_SLTU:          op_sel = ALU_SLTU;
                    FN_JR:
                    begin
                        r.reg_write = 1'b0;
                        r.write_reg = '0;
                        r.jump = 1'b1;
                        r.jump_target = a;
                    end
                    default:
                    begin
                        r.reg_write = 1'b0;
                        r.write_reg = '0;
                        r.illegal = 1'b1;
                    end
                endcase
            end
            OP_J:
            begin
                r.jump = 1'b1;
                r.jump_target = far_target;
            end
            OP_JAL:
            begin
                r.jump = 1'b1;
                r.jump_target = far_target;
                r.link = 1'b1;
                r.reg_write = 1'b1;
                r.write_reg = LINK_REG;
                op_sel = ALU_PASS_PC;
            end
            OP_BEQ:
            begin
                op_sel = ALU_SUB;
                r.branch_taken = (a == b);
            end
            OP_BNE:
            begin
                op_sel = ALU_SUB;
                r.branch_taken = (a != b);
            end
            OP_ADDIU, OP_SLTI, OP_LW:
            begin
                op_sel = (w[31:26] == OP_SLTI) ? ALU_SLT : ALU_ADD;
                operand_b = imm_ext;
                r.reg_write = 1'b1;
                r.write_reg = w[20:16];
                r.mem_read = (w[31:26] == OP_LW);
            end
            OP_SW:
            begin
                op_sel = ALU_ADD;
                operand_b = imm_ext;
                r.mem_write = 1'b1;
            end
            default:
                r.illegal = 1'b1;
        endcase
        case (op_sel)
            ALU_ADD:     r.alu_result = a + operand_b;
            ALU_SUB:     r.alu_result = a - operand_b;
            ALU_AND:     r.alu_result = a & operand_b;
            ALU_OR:      r.alu_result = a | operand_b;
            ALU_NOR:     r.alu_result = ~(a | operand_b);
            ALU_SLT:     r.alu_result = ($signed(a) < $signed(operand_b)) ? 32'd1 : 32'd0;
            ALU_SLTU:    r.alu_result = (a < operand_b) ? 32'd1 : 32'd0;
            ALU_SLL:     r.alu_result = b << w[10:6];
            ALU_SRL:     r.alu_result = b >> w[10:6];
            ALU_PASS_PC: r.alu_result = pc;
            default:     r.alu_result = '0;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Everything is sampled at the rising edge, so the values seen here are the ones
    // that were stable during the cycle that the edge closes. A result is retired
    // before a new expectation is queued, so the two never collide.
    always @(posedge clk)
    begin : scoreboard
        exec_result_t got;
        exec_result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                got = '{alu_result, write_reg, reg_write, mem_read, mem_write, store_data,
                        branch_taken, jump, jump_target, link, illegal};
                if (expected_exec.size() == 0)
                begin
                    $error("result transfer with no instruction outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_exec.pop_front();
                    check_field("alu_result", want.alu_result, got.alu_result);
                    check_field("write_reg", XLEN'(want.write_reg), XLEN'(got.write_reg));
                    check_field("reg_write", XLEN'(want.reg_write), XLEN'(got.reg_write));
                    check_field("mem_read", XLEN'(want.mem_read), XLEN'(got.mem_read));
                    check_field("mem_write", XLEN'(want.mem_write), XLEN'(got.mem_write));
                    check_field("store_data", want.store_data, got.store_data);
                    check_field("branch_taken", XLEN'(want.branch_taken),
                                XLEN'(got.branch_taken));
                    check_field("jump", XLEN'(want.jump), XLEN'(got.jump));
                    check_field("jump_target", want.jump_target, got.jump_target);
                    check_field("link", XLEN'(want.link), XLEN'(got.link));
                    check_field("illegal", XLEN'(want.illegal), XLEN'(got.illegal));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                if (row_known)
                    expected_exec.push_back(row_want);
                else
                    expected_exec.push_back(execute_instr(instr, rs_value, rt_value, next_pc));
            end
        end
    end

    // Presents one instruction and holds it until the block takes it. Start stays high
    // on return, so a following call keeps the transfers back to back.
    task automatic issue_instr(input logic [XLEN-1:0] w, input logic [XLEN-1:0] a,
                               input logic [XLEN-1:0] b, input logic [XLEN-1:0] pc,
                               input bit known, input exec_result_t want);
        start <= 1'b1;
        instr <= w;
        rs_value <= a;
        rt_value <= b;
        next_pc <= pc;
        row_known <= known;
        row_want <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Idle cycles carry random junk on the payload, which the block must ignore.
    task automatic idle_burst(input bit allowed);
        int cycles;
        cycles = $urandom_range(1, 19);
        if (allowed && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat (cycles)
            begin
                instr <= $urandom;
                rs_value <= $urandom;
                rt_value <= $urandom;
                next_pc <= $urandom;
                @(posedge clk);
            end
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_pipe();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_exec.size() != 0);
    endtask

    // Operand values lean on the corners of the 32-bit range.
    function automatic logic [XLEN-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t row(input logic [XLEN-1:0] w, input logic [XLEN-1:0] a,
                                      input logic [XLEN-1:0] b, input logic [XLEN-1:0] pc);
        return '{w, a, b, pc, 1'b0, '0};
    endfunction

    function automatic stim_row_t row_known_as(input logic [XLEN-1:0] w,
                                               input logic [XLEN-1:0] a,
                                               input logic [XLEN-1:0] b,
                                               input logic [XLEN-1:0] pc,
                                               input exec_result_t want);
        return '{w, a, b, pc, 1'b1, want};
    endfunction

    initial
    begin : stimulus
        logic [5:0]      r_functs[12];
        logic [5:0]      i_ops[8];
        stim_row_t       rows[$];
        logic [XLEN-1:0] w;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        int unsigned     kind;
        int              wait_cycles;

        r_functs = '{FN_SLL, FN_SRL, FN_JR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
                     FN_AND, FN_OR, FN_NOR, FN_SLT, FN_SLTU};
        i_ops = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTI, OP_LW, OP_SW};

        // Directed table. Typed results list the fields in port order.
        // Sums and differences wrap with no overflow flag.
        rows.push_back(row_known_as(enc_r(FN_ADDU, 5'd1, 5'd2, 5'd3, 5'd0),
            32'hFFFF_FFFF, 32'h0000_0001, 32'h0,
            '{32'h0, 5'd3, 1'b1, 1'b0, 1'b0, 32'h1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        rows.push_back(row_known_as(enc_r(FN_ADD, 5'd1, 5'd2, 5'd4, 5'd0),
            32'h7FFF_FFFF, 32'h0000_0001, 32'h0,
            '{32'h8000_0000, 5'd4, 1'b1, 1'b0, 1'b0, 32'h1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        rows.push_back(row(enc_r(FN_SUB, 5'd5, 5'd6, 5'd7, 5'd0), 32'h0, 32'h1, 32'h0));
        rows.push_back(row(enc_r(FN_AND, 5'd1, 5'd2, 5'd3, 5'd0),
            32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h0));
        rows.push_back(row(enc_r(FN_OR, 5'd1, 5'd2, 5'd3, 5'd0),
            32'h0F0F_0000, 32'h0000_F0F0, 32'h0));
        rows.push_back(row_known_as(enc_r(FN_NOR, 5'd0, 5'd0, 5'd31, 5'd0),
            32'h0, 32'h0, 32'h0,
            '{32'hFFFF_FFFF, 5'd31, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        // Most negative against most positive: signed and unsigned answers differ.
        rows.push_back(row_known_as(enc_r(FN_SLT, 5'd1, 5'd2, 5'd5, 5'd0),
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
            '{32'h1, 5'd5, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        rows.push_back(row_known_as(enc_r(FN_SLTU, 5'd1, 5'd2, 5'd6, 5'd0),
            32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
            '{32'h0, 5'd6, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        // Full-width shifts; srl must bring in zeros.
        rows.push_back(row_known_as(enc_r(FN_SLL, 5'd0, 5'd2, 5'd7, 5'd31),
            32'hFFFF_FFFF, 32'h1, 32'h0,
            '{32'h8000_0000, 5'd7, 1'b1, 1'b0, 1'b0, 32'h1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        rows.push_back(row_known_as(enc_r(FN_SRL, 5'd0, 5'd2, 5'd8, 5'd31),
            32'h0, 32'h8000_0000, 32'h0,
            '{32'h1, 5'd8, 1'b1, 1'b0, 1'b0, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0}));
        // Register jump: no write even though the rd field is set.
        rows.push_back(row_known_as(enc_r(FN_JR, 5'd1, 5'd0, 5'd9, 5'd0),
            32'hFFFF_FFFC, 32'h1234_5678, 32'h0,
            '{32'h0, 5'd0, 1'b0, 1'b0, 1'b0, 32'h1234_5678, 1'b0, 1'b1, 32'hFFFF_FFFC,
              1'b0, 1'b0}));
        rows.push_back(row(enc_i(OP_ADDIU, 5'd1, 5'd10, 16'h8000), 32'h0, 32'h5, 32'h0));
        rows.push_back(row(enc_i(OP_SLTI, 5'd1, 5'd11, 16'hFFFF), 32'h8000_0000, 32'h0, 32'h0));
        rows.push_back(row(enc_i(OP_SLTI, 5'd1, 5'd12, 16'hFFFF), 32'h0, 32'h0, 32'h0));
        rows.push_back(row(enc_i(OP_LW, 5'd1, 5'd13, 16'h7FFF), 32'hFFFF_FFFF, 32'h0, 32'h0));
        rows.push_back(row(enc_i(OP_SW, 5'd1, 5'd14, 16'h7FFF),
            32'h7FFF_FFFF, 32'hCAFE_F00D, 32'h0));
        rows.push_back(row(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0004), 32'h1234_5678, 32'h1234_5678, 0));
        rows.push_back(row(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h0004), 32'h1234_5678, 32'h1234_5679, 0));
        rows.push_back(row(enc_i(OP_BNE, 5'd1, 5'd2, 16'hFFFC), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        rows.push_back(row(enc_i(OP_BNE, 5'd1, 5'd2, 16'hFFFC), 32'h0, 32'h8000_0000, 32'h0));
        // Long jumps take the top nibble of the sequential PC.
        rows.push_back(row_known_as(enc_j(OP_J, 26'h3FF_FFFF), 32'h0, 32'h0, 32'hFFFF_FFFF,
            '{32'h0, 5'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1, 32'hFFFF_FFFC, 1'b0, 1'b0}));
        rows.push_back(row_known_as(enc_j(OP_JAL, 26'h0), 32'h0, 32'h0, 32'hF000_0004,
            '{32'hF000_0004, 5'd31, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1, 32'hF000_0000,
              1'b1, 1'b0}));
        // Unknown opcode and unknown function code: only store_data survives.
        rows.push_back(row_known_as(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            '{32'h0, 5'd0, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1}));
        rows.push_back(row_known_as(32'h03FF_FFFF, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 32'hFFFF_FFFF,
            '{32'h0, 5'd0, 1'b0, 1'b0, 1'b0, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b1}));
        // The all-zero word is a plain sll into register zero.
        rows.push_back(row(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            issue_instr(rows[i].instr, rows[i].rs_value, rows[i].rt_value, rows[i].next_pc,
                        rows[i].known, rows[i].want);
            idle_burst(1'b1);
        end
        drain_pipe();

        // Random part: mostly legal instructions with random fields, the rest noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            w = $urandom;
            a = pick_word();
            b = pick_word();
            kind = $urandom_range(0, 23);
            if (kind < 12)
            begin
                w[31:26] = OP_RTYPE;
                w[5:0] = r_functs[kind[3:0]];
            end
            else if (kind < 20)
            begin
                w[31:26] = i_ops[3'(kind - 12)];
                // Give equal operands a fair share so both branch outcomes occur.
                if ($urandom_range(0, 1) == 1)
                    b = a;
            end
            else if (kind == 20)
                w[31:26] = OP_RTYPE;
            issue_instr(w, a, b, pick_word(), 1'b0, '0);
            idle_burst(n < RANDOM_ITEMS - CALM_TAIL);
            if (n == RANDOM_ITEMS / 2)
                drain_pipe();
        end

        start <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 200 && expected_exec.size() != 0; wait_cycles++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_exec.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_exec.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
